[hdl/tsfc_pkg.sv]
// ----------------------------------------------------------------------------
// tsfc_pkg: shared types and constants of the thermal supervisor
// Event codes, register indexes, reset values and the structs that join the
// controller, the datapath and the register file.
// ----------------------------------------------------------------------------
`default_nettype none

package tsfc_pkg;

  // Event codes carried in the command field of an input word.
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_ALERT  = 2'd2,
    CMD_PIN    = 2'd3
  } cmd_e;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_KILL_TEMP     = 3'd0,
    REG_WARN_TEMP     = 3'd1,
    REG_FAN_FULL_TEMP = 3'd2,
    REG_FAN_OFF_TEMP  = 3'd3,
    REG_MIN_FAN_DUTY  = 3'd4
  } reg_e;

  localparam int unsigned TempW  = 8;
  localparam int unsigned DutyW  = 7;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // Divider sizing: the quotient never exceeds the duty scale of 100.
  localparam int unsigned QuotW  = 7;
  localparam int unsigned RemW   = 15;
  localparam int unsigned StepW  = 3;

  localparam logic [DutyW-1:0] DutyScale = 7'd100;
  localparam logic [DutyW-1:0] DutyMax   = 7'd99;
  localparam logic [DutyW-1:0] DutyReset = 7'd50;

  localparam logic signed [TempW-1:0] KillTempReset    = 8'sd65;
  localparam logic signed [TempW-1:0] WarnTempReset    = 8'sd55;
  localparam logic signed [TempW-1:0] FanFullTempReset = 8'sd50;
  localparam logic signed [TempW-1:0] FanOffTempReset  = 8'sd35;
  localparam logic [DutyW-1:0]        MinFanDutyReset  = 7'd95;

  // Configuration values as seen by the datapath.
  typedef struct packed {
    logic signed [TempW-1:0] kill_temp;
    logic signed [TempW-1:0] warn_temp;
    logic signed [TempW-1:0] fan_full_temp;
    logic signed [TempW-1:0] fan_off_temp;
    logic [DutyW-1:0]        min_fan_duty;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic push;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
  } dp_status_t;

  // One result word.
  typedef struct packed {
    logic             power_enable;
    logic             ok_led;
    logic             err_led;
    logic [DutyW-1:0] fan_duty;
    logic             killed;
  } result_t;

endpackage

`default_nettype wire

[hdl/tsfc_if.sv]
// ----------------------------------------------------------------------------
// tsfc_in_if / tsfc_out_if: event and result channels
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsfc_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [7:0] temperature;
  logic              reset_pin_high;

  modport source (output valid, command, temperature, reset_pin_high, input ready);
  modport sink   (input valid, command, temperature, reset_pin_high, output ready);
endinterface

interface tsfc_out_if;
  logic       valid;
  logic       ready;
  logic       power_enable;
  logic       ok_led;
  logic       err_led;
  logic [6:0] fan_duty;
  logic       killed;

  modport source (output valid, power_enable, ok_led, err_led, fan_duty, killed,
                  input ready);
  modport sink   (input valid, power_enable, ok_led, err_led, fan_duty, killed,
                  output ready);
endinterface

`default_nettype wire

[hdl/tsfc_regs.sv]
// ----------------------------------------------------------------------------
// tsfc_regs: configuration register file
// APB-style slave holding the temperature thresholds and the fan duty floor.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfc_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tsfc_pkg::AddrW-1:0]  paddr,
  input  wire logic [tsfc_pkg::DataW-1:0]  pwdata,
  output logic      [tsfc_pkg::DataW-1:0]  prdata,
  output logic                             pready,
  output tsfc_pkg::cfg_t                   cfg_o
);
  import tsfc_pkg::*;

  cfg_t cfg_q;
  logic wr_en;
  reg_e idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_e'(paddr[AddrW-1:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kill_temp     <= KillTempReset;
      cfg_q.warn_temp     <= WarnTempReset;
      cfg_q.fan_full_temp <= FanFullTempReset;
      cfg_q.fan_off_temp  <= FanOffTempReset;
      cfg_q.min_fan_duty  <= MinFanDutyReset;
    end else if (wr_en) begin
      case (idx)
        REG_KILL_TEMP:     cfg_q.kill_temp     <= pwdata[TempW-1:0];
        REG_WARN_TEMP:     cfg_q.warn_temp     <= pwdata[TempW-1:0];
        REG_FAN_FULL_TEMP: cfg_q.fan_full_temp <= pwdata[TempW-1:0];
        REG_FAN_OFF_TEMP:  cfg_q.fan_off_temp  <= pwdata[TempW-1:0];
        REG_MIN_FAN_DUTY:  cfg_q.min_fan_duty  <= pwdata[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // Read-back; temperatures come back sign-extended.
  always_comb begin
    case (idx)
      REG_KILL_TEMP:     prdata = DataW'(cfg_q.kill_temp);
      REG_WARN_TEMP:     prdata = DataW'(cfg_q.warn_temp);
      REG_FAN_FULL_TEMP: prdata = DataW'(cfg_q.fan_full_temp);
      REG_FAN_OFF_TEMP:  prdata = DataW'(cfg_q.fan_off_temp);
      REG_MIN_FAN_DUTY:  prdata = DataW'(cfg_q.min_fan_duty);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/tsfc_ctrl.sv]
// ----------------------------------------------------------------------------
// tsfc_ctrl: sequencing state machine
// Accepts an event word, runs the duty divider for samples and hands the
// finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              is_sample_i,
  input  wire logic              out_free_i,
  input  wire tsfc_pkg::dp_status_t status_i,
  output logic                   in_ready_o,
  output tsfc_pkg::ctrl_cmd_t    cmd_o
);
  import tsfc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_FIN  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.load  = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = is_sample_i ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The last divide step always leads to the duty update.
  a_div_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && status_i.div_last) |=> (state_q == S_FIN))
    else $error("divider did not hand over to the duty update");

endmodule

`default_nettype wire

[hdl/tsfc_dp.sv]
// ----------------------------------------------------------------------------
// tsfc_dp: supervisor state and fan duty datapath
// Holds power, LED and duty state; applies events and computes the ramp duty
// with a restoring divider that resolves one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfc_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tsfc_pkg::cfg_t              cfg_i,
  input  wire tsfc_pkg::ctrl_cmd_t         cmd_i,
  input  wire logic [1:0]                  command_i,
  input  wire logic signed [tsfc_pkg::TempW-1:0] temperature_i,
  input  wire logic                        reset_pin_high_i,
  output tsfc_pkg::dp_status_t             status_o,
  output tsfc_pkg::result_t                result_o
);
  import tsfc_pkg::*;

  // Supervisor state.
  logic             killed_q, power_q, ok_q, err_q;
  logic [DutyW-1:0] duty_q;

  // Divider registers.
  logic [RemW-1:0]  rem_q;
  logic [TempW-1:0] span_q;
  logic [QuotW-1:0] quot_q;
  logic [StepW-1:0] step_q;
  logic             empty_q;

  // Sample decode.
  cmd_e                    cmd;
  logic                    fault, hot_kill, hot_warn, empty;
  logic signed [TempW:0]   span;
  logic signed [TempW-1:0] tc;
  logic signed [TempW:0]   diff;
  logic [RemW-1:0]         num;

  // Divide step and duty finish.
  logic [RemW-1:0]  divisor_sh;
  logic             take;
  logic [DutyW-1:0] quot_cap, floor_duty, duty_new;

  assign cmd = cmd_e'(command_i);

  // Thresholds and ramp numerator for a new sample.
  always_comb begin
    fault    = (temperature_i == '0);
    hot_kill = fault || (temperature_i >= cfg_i.kill_temp);
    hot_warn = (temperature_i >= cfg_i.warn_temp);
    span     = (TempW+1)'(cfg_i.fan_full_temp) - (TempW+1)'(cfg_i.fan_off_temp);
    empty    = (span <= 0);
    if (fault || temperature_i > cfg_i.fan_full_temp) begin
      tc = cfg_i.fan_full_temp;
    end else begin
      tc = temperature_i;
    end
    if (tc < cfg_i.fan_off_temp) begin
      tc = cfg_i.fan_off_temp;
    end
    diff = (TempW+1)'(tc) - (TempW+1)'(cfg_i.fan_off_temp);
    num  = RemW'(diff[TempW-1:0]) * RemW'(DutyScale);
  end

  // One quotient bit per cycle, most significant first.
  always_comb begin
    divisor_sh = RemW'(span_q) << step_q;
    take       = (rem_q >= divisor_sh);
  end

  // Cap, floor and empty ramp applied to the quotient.
  always_comb begin
    quot_cap   = (quot_q > DutyMax) ? DutyMax : quot_q;
    floor_duty = (cfg_i.min_fan_duty > DutyMax) ? DutyMax : cfg_i.min_fan_duty;
    duty_new   = empty_q ? '0 : quot_cap;
    if (duty_new != '0 && duty_new < floor_duty) begin
      duty_new = floor_duty;
    end
  end

  // Divider registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q   <= empty ? '0 : num;
      span_q  <= empty ? TempW'(1) : span[TempW-1:0];
      empty_q <= empty;
      quot_q  <= '0;
      step_q  <= StepW'(QuotW - 1);
    end else if (cmd_i.step) begin
      if (take) begin
        rem_q          <= rem_q - divisor_sh;
        quot_q[step_q] <= 1'b1;
      end
      step_q <= step_q - 1'b1;
    end
  end

  // Event handling on the supervisor state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      killed_q <= 1'b0;
      power_q  <= 1'b1;
      ok_q     <= 1'b0;
      err_q    <= 1'b0;
      duty_q   <= DutyReset;
    end else begin
      if (cmd_i.load) begin
        case (cmd)
          CMD_SAMPLE: begin
            if (hot_kill) begin
              killed_q <= 1'b1;
              power_q  <= 1'b0;
              ok_q     <= 1'b0;
              err_q    <= 1'b1;
            end else if (hot_warn) begin
              ok_q  <= 1'b0;
              err_q <= 1'b1;
            end else begin
              ok_q  <= 1'b1;
              err_q <= 1'b0;
            end
          end
          CMD_TICK: begin
            if (killed_q) begin
              err_q <= ~err_q;
            end
          end
          CMD_ALERT: begin
            killed_q <= 1'b1;
            power_q  <= 1'b0;
          end
          CMD_PIN: begin
            killed_q <= ~reset_pin_high_i;
            power_q  <= reset_pin_high_i;
          end
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        duty_q <= duty_new;
      end
    end
  end

  assign status_o.div_last      = (step_q == '0);
  assign result_o.power_enable  = power_q;
  assign result_o.ok_led        = ok_q;
  assign result_o.err_led       = err_q;
  assign result_o.fan_duty      = duty_q;
  assign result_o.killed        = killed_q;

  // Power is on exactly when the supervisor is not latched off.
  a_kill_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    killed_q != power_q)
    else $error("killed and power enable disagree");

  // The duty never leaves the percent range.
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q <= DutyMax)
    else $error("fan duty above maximum");

  // The remainder stays below twice the current shifted divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (16'(rem_q) < (16'(span_q) << (4'(step_q) + 4'd1))))
    else $error("divider remainder out of range");

endmodule

`default_nettype wire

[hdl/thermal_supervisor_fan_control.sv]
// ----------------------------------------------------------------------------
// thermal_supervisor_fan_control: thermal supervisor with fan duty ramp
// Applies temperature, tick, alert and reset-pin events to the power, LED and
// fan state and reports the state after each event.
//
//   Channel  Direction  Handshake            Word
//   in_i     in         valid/ready          command, temperature, reset_pin_high
//   out_o    out        valid/ready          power_enable, ok_led, err_led,
//                                            fan_duty, killed
//   APB      in         psel/penable/pready  five config registers at 4*i
//
// A sample passes through seven divide steps, one duty update and the hand-over
// to the output register; other events go straight to the hand-over. The next
// event is taken the cycle after the hand-over, never while one is in progress.
// A sink stall holds the next result in the datapath and the controller in its
// done state until the output register frees, blocking the input.
// Reset restores the configuration and supervisor state; divider data needs none.
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_supervisor_fan_control (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  tsfc_in_if.sink                          in_i,
  tsfc_out_if.source                       out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tsfc_pkg::AddrW-1:0]  paddr,
  input  wire logic [tsfc_pkg::DataW-1:0]  pwdata,
  output logic      [tsfc_pkg::DataW-1:0]  prdata,
  output logic                             pready
);
  import tsfc_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  result_t    result;
  result_t    out_q;
  logic       out_valid_q;
  logic       out_free;
  logic       is_sample;

  assign is_sample = (cmd_e'(in_i.command) == CMD_SAMPLE);
  assign out_free  = ~out_valid_q | out_o.ready;

  tsfc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .is_sample_i (is_sample),
    .out_free_i  (out_free),
    .status_i    (status),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd)
  );

  tsfc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .command_i        (in_i.command),
    .temperature_i    (in_i.temperature),
    .reset_pin_high_i (in_i.reset_pin_high),
    .status_o         (status),
    .result_o         (result)
  );

  // Output register: holds a finished word until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.push) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.push) begin
      out_q <= result;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.power_enable = out_q.power_enable;
  assign out_o.ok_led       = out_q.ok_led;
  assign out_o.err_led      = out_q.err_led;
  assign out_o.fan_duty     = out_q.fan_duty;
  assign out_o.killed       = out_q.killed;

endmodule

`default_nettype wire

[tb/thermal_supervisor_fan_control_tb.sv]
// ----------------------------------------------------------------------------
// thermal_supervisor_fan_control_tb: self-checking regression of the supervisor
// Feeds temperature samples, fast ticks, alerts and reset-pin levels through
// the event channel under several register settings. A predictor of the power,
// LED and fan state works out the status word due for every accepted event,
// and the monitor compares each returned word with it, field by field.
// ----------------------------------------------------------------------------
module thermal_supervisor_fan_control_tb;
  import tsfc_pkg::*;

  // One event word as presented on the input channel.
  typedef struct packed {
    cmd_e              command;
    logic signed [7:0] temperature;
    logic              reset_pin_high;
  } supervisor_evt_t;

  // Register slots past the last one; writes there must change nothing.
  localparam logic [2:0] RegUnusedLow  = 3'd5;
  localparam logic [2:0] RegUnusedHigh = 3'd7;

  localparam int SettleCycles = 12;
  localparam int DrainCycles  = 20;
  localparam int QuietLimit   = 2000;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  tsfc_in_if  evt_if ();
  tsfc_out_if res_if ();

  // Predicted register settings.
  logic signed [7:0] lim_kill;
  logic signed [7:0] lim_warn;
  logic signed [7:0] lim_full;
  logic signed [7:0] lim_off;
  logic [6:0]        lim_floor;

  // Predicted supervisor state, starting from the reset values.
  logic              sv_killed = 1'b0;
  logic              sv_power  = 1'b1;
  logic              sv_ok     = 1'b0;
  logic              sv_err    = 1'b0;
  logic [6:0]        sv_duty   = DutyReset;

  supervisor_evt_t   pending_evt_q[$];
  result_t           status_due_q[$];

  int                send_gap;
  int                stall_left;
  int                fail_count = 0;
  int                quiet_cycles;
  bit                calm;

  thermal_supervisor_fan_control uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (evt_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Fan duty for a sample: linear between the off and full temperatures,
  // capped below full scale and lifted to the floor when nonzero.
  function automatic logic [6:0] fan_percent(logic signed [7:0] t, logic fault);
    int span;
    int tc;
    int pct;
    int floor_pct;
    span = int'(lim_full) - int'(lim_off);
    if (span <= 0) begin
      return '0;
    end
    tc = int'(t);
    if (fault || tc > int'(lim_full)) begin
      tc = int'(lim_full);
    end
    if (tc < int'(lim_off)) begin
      tc = int'(lim_off);
    end
    pct = ((tc - int'(lim_off)) * int'(DutyScale)) / span;
    if (pct > int'(DutyMax)) begin
      pct = int'(DutyMax);
    end
    floor_pct = (int'(lim_floor) > int'(DutyMax)) ? int'(DutyMax) : int'(lim_floor);
    if (pct > 0 && pct < floor_pct) begin
      pct = floor_pct;
    end
    return pct[6:0];
  endfunction

  // Applies one event to the predicted state and returns the status word due.
  function automatic result_t supervise_apply(supervisor_evt_t e);
    result_t r;
    logic    fault;
    case (e.command)
      CMD_SAMPLE: begin
        fault = (e.temperature == 8'sd0);
        if (fault || e.temperature >= lim_kill) begin
          sv_power  = 1'b0;
          sv_killed = 1'b1;
          sv_ok     = 1'b0;
          sv_err    = 1'b1;
        end else if (e.temperature >= lim_warn) begin
          sv_ok  = 1'b0;
          sv_err = 1'b1;
        end else begin
          sv_ok  = 1'b1;
          sv_err = 1'b0;
        end
        sv_duty = fan_percent(e.temperature, fault);
      end
      CMD_TICK: begin
        if (sv_killed) begin
          sv_err = ~sv_err;
        end
      end
      CMD_ALERT: begin
        sv_power  = 1'b0;
        sv_killed = 1'b1;
      end
      default: begin
        if (e.reset_pin_high) begin
          sv_power  = 1'b1;
          sv_killed = 1'b0;
        end else begin
          sv_power  = 1'b0;
          sv_killed = 1'b1;
        end
      end
    endcase
    r.power_enable = sv_power;
    r.ok_led       = sv_ok;
    r.err_led      = sv_err;
    r.fan_duty     = sv_duty;
    r.killed       = sv_killed;
    return r;
  endfunction

  // Sign-extends a temperature setting to a bus word.
  function automatic logic [DataW-1:0] temp_word(int v);
    return {{(DataW-8){v[7]}}, v[7:0]};
  endfunction

  // A random event, weighted towards samples near the current thresholds.
  function automatic supervisor_evt_t random_evt();
    supervisor_evt_t e;
    int              pick;
    int              base;
    pick             = $urandom_range(0, 99);
    e.temperature    = 8'($urandom);
    e.reset_pin_high = 1'($urandom_range(0, 1));
    if (pick < 55) begin
      e.command = CMD_SAMPLE;
      case ($urandom_range(0, 9))
        0: e.temperature = 8'sd0;
        1, 2, 3, 4: begin
          case ($urandom_range(0, 3))
            0:       base = int'(lim_kill);
            1:       base = int'(lim_warn);
            2:       base = int'(lim_full);
            default: base = int'(lim_off);
          endcase
          base          = base + int'($urandom_range(0, 4)) - 2;
          e.temperature = base[7:0];
        end
        default: ;
      endcase
    end else if (pick < 67) begin
      e.command = CMD_TICK;
    end else if (pick < 77) begin
      e.command = CMD_ALERT;
    end else begin
      // Mostly raise the pin so that the latched-off state is left again.
      e.command        = CMD_PIN;
      e.reset_pin_high = ($urandom_range(0, 9) < 7);
    end
    return e;
  endfunction

  task automatic push_evt(cmd_e c, int t, bit pin);
    supervisor_evt_t e;
    e.command        = c;
    e.temperature    = t[7:0];
    e.reset_pin_high = pin;
    pending_evt_q.push_back(e);
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      pending_evt_q.push_back(random_evt());
    end
  endtask

  // Waits until every queued word is accepted and every status word returned.
  task automatic wait_until_drained();
    @(negedge clk_i);
    while (pending_evt_q.size() != 0 || evt_if.valid || status_due_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // APB write: setup cycle, then an access cycle that completes with pready.
  task automatic reg_write(logic [2:0] index, logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      REG_KILL_TEMP:     lim_kill  = value[7:0];
      REG_WARN_TEMP:     lim_warn  = value[7:0];
      REG_FAN_FULL_TEMP: lim_full  = value[7:0];
      REG_FAN_OFF_TEMP:  lim_off   = value[7:0];
      REG_MIN_FAN_DUTY:  lim_floor = value[6:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(int kill, int warn, int full, int off, int floor_pct);
    reg_write(REG_KILL_TEMP, temp_word(kill));
    reg_write(REG_WARN_TEMP, temp_word(warn));
    reg_write(REG_FAN_FULL_TEMP, temp_word(full));
    reg_write(REG_FAN_OFF_TEMP, temp_word(off));
    reg_write(REG_MIN_FAN_DUTY, {{(DataW-7){1'b0}}, floor_pct[6:0]});
  endtask

  // Either any values at all, or a sensible ramp with thresholds around it.
  task automatic random_limits(bit wild);
    int lo;
    if (wild) begin
      set_limits($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 127));
    end else begin
      lo = int'($urandom_range(0, 140)) - 100;
      set_limits(lo + int'($urandom_range(10, 80)), lo + int'($urandom_range(0, 70)),
                 lo + int'($urandom_range(1, 60)), lo, $urandom_range(0, 99));
    end
  endtask

  task automatic check_field(string what, logic [6:0] due, logic [6:0] seen);
    if (seen !== due) begin
      fail_count++;
      if (fail_count <= 40) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, due, seen);
      end
    end
  endtask

  // Event driver: presents the next pending word once the previous one has
  // gone, with random gaps between words outside the calm part of the run.
  always @(posedge clk_i or negedge rst_ni) begin : drive_events
    supervisor_evt_t shown;
    supervisor_evt_t nxt;
    logic            took;
    if (!rst_ni) begin
      evt_if.valid          <= 1'b0;
      evt_if.command        <= CMD_SAMPLE;
      evt_if.temperature    <= '0;
      evt_if.reset_pin_high <= 1'b0;
      send_gap = 0;
    end else begin
      took = evt_if.valid && evt_if.ready;
      if (took) begin
        shown.command        = cmd_e'(evt_if.command);
        shown.temperature    = evt_if.temperature;
        shown.reset_pin_high = evt_if.reset_pin_high;
        status_due_q.push_back(supervise_apply(shown));
      end
      if (!evt_if.valid || took) begin
        if (send_gap > 0) begin
          send_gap--;
          evt_if.valid <= 1'b0;
        end else if (pending_evt_q.size() == 0) begin
          evt_if.valid <= 1'b0;
        end else begin
          nxt = pending_evt_q.pop_front();
          evt_if.valid          <= 1'b1;
          evt_if.command        <= nxt.command;
          evt_if.temperature    <= nxt.temperature;
          evt_if.reset_pin_high <= nxt.reset_pin_high;
          if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Result monitor: checks each accepted status word against the oldest one
  // due, and stalls the output channel in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin : watch_status
    result_t due;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (status_due_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected status word, expected none, actual %b%b%b/%0d/%b",
                   $time, res_if.power_enable, res_if.ok_led, res_if.err_led,
                   res_if.fan_duty, res_if.killed);
        end else begin
          due = status_due_q.pop_front();
          check_field("power_enable", due.power_enable, res_if.power_enable);
          check_field("ok_led", due.ok_led, res_if.ok_led);
          check_field("err_led", due.err_led, res_if.err_led);
          check_field("fan_duty", due.fan_duty, res_if.fan_duty);
          check_field("killed", due.killed, res_if.killed);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run after too long without any word or bus access.
  always @(posedge clk_i) begin
    if (!rst_ni || (evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("thermal_supervisor_fan_control regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed events under the reset settings, then random phases
  // under extreme and random settings, the last one without any idling.
  initial begin
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    calm                  = 1'b0;
    lim_kill              = KillTempReset;
    lim_warn              = WarnTempReset;
    lim_full              = FanFullTempReset;
    lim_off               = FanOffTempReset;
    lim_floor             = MinFanDutyReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Thresholds, ramp ends, sensor fault, ticks in and out of the killed
    // state, the alert and both pin levels.
    push_evt(CMD_TICK, 0, 1'b0);
    push_evt(CMD_SAMPLE, 20, 1'b0);
    push_evt(CMD_SAMPLE, 40, 1'b0);
    push_evt(CMD_SAMPLE, 54, 1'b0);
    push_evt(CMD_SAMPLE, 55, 1'b0);
    push_evt(CMD_SAMPLE, 64, 1'b1);
    push_evt(CMD_SAMPLE, 65, 1'b0);
    push_evt(CMD_TICK, 0, 1'b0);
    push_evt(CMD_TICK, -1, 1'b1);
    push_evt(CMD_PIN, 0, 1'b1);
    push_evt(CMD_SAMPLE, 0, 1'b0);
    push_evt(CMD_PIN, 0, 1'b1);
    push_evt(CMD_ALERT, 0, 1'b0);
    push_evt(CMD_TICK, 0, 1'b0);
    push_evt(CMD_PIN, 0, 1'b0);
    push_evt(CMD_PIN, 0, 1'b1);
    push_evt(CMD_SAMPLE, 127, 1'b1);
    push_evt(CMD_PIN, -128, 1'b1);
    push_evt(CMD_SAMPLE, -128, 1'b0);
    push_evt(CMD_SAMPLE, 36, 1'b0);
    push_evt(CMD_SAMPLE, 50, 1'b0);
    push_evt(CMD_SAMPLE, 51, 1'b0);
    push_evt(CMD_SAMPLE, 35, 1'b0);
    wait_until_drained();

    // Widest ramp, no floor; writes to the unused slots must be ignored.
    repeat (SettleCycles) @(posedge clk_i);
    set_limits(127, -128, 127, -128, 0);
    reg_write(RegUnusedLow, temp_word(-7));
    reg_write(RegUnusedHigh, 32'hFFFF_FFFF);
    push_random(80);
    wait_until_drained();

    // Everything kills, ramp empty because it runs backwards, floor too big.
    repeat (SettleCycles) @(posedge clk_i);
    set_limits(-128, 127, -128, 127, 127);
    push_random(40);
    wait_until_drained();

    // Ramp of zero span, floor just above the maximum duty.
    repeat (SettleCycles) @(posedge clk_i);
    set_limits($urandom, $urandom, 20, 20, 100);
    push_random(60);
    wait_until_drained();

    for (int ph = 0; ph < 4; ph++) begin
      repeat (SettleCycles) @(posedge clk_i);
      random_limits(ph == 3);
      push_random(35);
      // Once, the sender holds off until every status word has come back.
      if (ph == 1) begin
        wait_until_drained();
      end
      push_random(35);
      wait_until_drained();
    end

    // Closing phase at full rate on both sides.
    repeat (SettleCycles) @(posedge clk_i);
    random_limits(1'b0);
    calm = 1'b1;
    push_random(90);
    wait_until_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("thermal_supervisor_fan_control regression: pass");
    end else begin
      $display("thermal_supervisor_fan_control regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/tsfc_pkg.sv
hdl/tsfc_if.sv
hdl/tsfc_regs.sv
hdl/tsfc_ctrl.sv
hdl/tsfc_dp.sv
hdl/thermal_supervisor_fan_control.sv
tb/thermal_supervisor_fan_control_tb.sv
